// ===== hw/rtl/u8d_pkg.sv =====
// Shared types and constants for the UTF-8 stream decoder.
package u8d_pkg;

    localparam int unsigned CP_W = 21;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

    // Byte class patterns and payload masks
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;
    localparam logic [7:0] BITS2_MASK = 8'h1F;
    localparam logic [7:0] BITS3_MASK = 8'h0F;
    localparam logic [7:0] BITS4_MASK = 8'h07;
    localparam logic [7:0] CONT_BITS  = 8'h3F;

    // Sequence lengths; zero means no sequence open
    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_LEN2 = 3'd2;
    localparam logic [2:0] SEQ_LEN3 = 3'd3;
    localparam logic [2:0] SEQ_LEN4 = 3'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } byte_word_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            run_last;
        logic            text_done;
    } cp_word_t;

endpackage

// ===== hw/rtl/u8d_byte_if.sv =====
// Byte channel: valid/ready handshake carrying one text byte per word.
interface u8d_byte_if;
    logic                valid;
    logic                ready;
    u8d_pkg::byte_word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/u8d_cp_if.sv =====
// Code point channel: valid/ready handshake carrying one decoded code point per word.
interface u8d_cp_if;
    logic              valid;
    logic              ready;
    u8d_pkg::cp_word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/utf8_stream_decoder.sv =====
// UTF-8 stream decoder: bytes in, code points out, U+FFFD for broken input.
//
//  channel       dir  word                                   handshake
//  byte_stream   in   in_byte[7:0], end_of_text              valid / ready
//  code_stream   out  code_point[20:0], run_last, text_done  valid / ready
//
// Each byte is decoded in the cycle it is taken and its results land in a
// burst register: up to three replacement words followed by at most one tail word.
// One word leaves per cycle while code_stream is ready; a byte is taken once
// the burst is empty or as the last word of the previous burst leaves.
// Reset clears the open sequence and empties the burst register.
module utf8_stream_decoder
(
    input  logic               clk,
    input  logic               rst_n,
    u8d_byte_if.sink           byte_stream,
    u8d_cp_if.source           code_stream
);
    import u8d_pkg::*;

    // Decoder state
    logic [CP_W-1:0] partial_reg, partial_next;
    logic [2:0]      seq_len_reg, seq_len_next;
    logic [1:0]      taken_reg, taken_next;

    // Burst register
    logic [1:0]      rep_reg, rep_next;
    logic            tail_valid_reg, tail_valid_next;
    logic [CP_W-1:0] tail_cp_reg, tail_cp_next;
    logic            last_reg, last_next;

    logic            in_fire, out_fire, burst_ends;
    logic [7:0]      b;
    logic            last_in, is_cont, completes;
    logic [2:0]      fresh_len;
    logic [CP_W-1:0] fresh_bits;
    logic [CP_W-1:0] shifted;

    // Output side
    always_comb
    begin
        code_stream.valid              = (rep_reg != 2'd0) || tail_valid_reg;
        code_stream.payload.code_point = (rep_reg != 2'd0) ? REPLACEMENT_CP : tail_cp_reg;
        code_stream.payload.run_last   = (rep_reg == 2'd0)
                                         || (rep_reg == 2'd1 && !tail_valid_reg);
        code_stream.payload.text_done  = code_stream.payload.run_last && last_reg;
    end

    assign out_fire   = code_stream.valid && code_stream.ready;
    assign burst_ends = out_fire && code_stream.payload.run_last;

    // Take a new byte once the burst is empty or its last word leaves now
    assign byte_stream.ready = !code_stream.valid || burst_ends;
    assign in_fire           = byte_stream.valid && byte_stream.ready;

    assign b         = byte_stream.payload.in_byte;
    assign last_in   = byte_stream.payload.end_of_text;
    assign is_cont   = (b & CONT_MASK) == CONT_CODE;
    assign completes = ({1'b0, taken_reg} + 3'd2) >= seq_len_reg;
    assign shifted   = {partial_reg[CP_W-7:0], b[5:0]};

    // Lead byte classification
    always_comb
    begin
        fresh_len  = SEQ_NONE;
        fresh_bits = '0;
        if ((b & LEAD2_MASK) == LEAD2_CODE)
        begin
            fresh_len  = SEQ_LEN2;
            fresh_bits = {13'd0, b & BITS2_MASK};
        end
        else if ((b & LEAD3_MASK) == LEAD3_CODE)
        begin
            fresh_len  = SEQ_LEN3;
            fresh_bits = {13'd0, b & BITS3_MASK};
        end
        else if ((b & LEAD4_MASK) == LEAD4_CODE)
        begin
            fresh_len  = SEQ_LEN4;
            fresh_bits = {13'd0, b & BITS4_MASK};
        end
    end

    always_comb
    begin
        partial_next    = partial_reg;
        seq_len_next    = seq_len_reg;
        taken_next      = taken_reg;
        rep_next        = rep_reg;
        tail_valid_next = tail_valid_reg;
        tail_cp_next    = tail_cp_reg;
        last_next       = last_reg;

        // Advance the burst
        if (out_fire)
        begin
            if (rep_reg != 2'd0)
            begin
                rep_next = rep_reg - 2'd1;
            end
            else
            begin
                tail_valid_next = 1'b0;
            end
        end

        if (in_fire)
        begin
            rep_next        = 2'd0;
            tail_valid_next = 1'b0;
            tail_cp_next    = REPLACEMENT_CP;
            last_next       = last_in;

            if (seq_len_reg != SEQ_NONE && is_cont && completes)
            begin
                tail_valid_next = 1'b1;
                tail_cp_next    = shifted;
                seq_len_next    = SEQ_NONE;
                taken_next      = 2'd0;
                partial_next    = '0;
            end
            else if (seq_len_reg != SEQ_NONE && is_cont && !last_in)
            begin
                partial_next = shifted;
                taken_next   = taken_reg + 2'd1;
            end
            else
            begin
                // Broken sequence: flush the lead and buffered bytes, then decode afresh
                if (seq_len_reg != SEQ_NONE)
                begin
                    rep_next = taken_reg + 2'd1;
                end
                seq_len_next = SEQ_NONE;
                taken_next   = 2'd0;
                partial_next = '0;
                if (b[7] == 1'b0)
                begin
                    tail_valid_next = 1'b1;
                    tail_cp_next    = {13'd0, b};
                end
                else if (fresh_len == SEQ_NONE || last_in)
                begin
                    tail_valid_next = 1'b1;
                end
                else
                begin
                    seq_len_next = fresh_len;
                    partial_next = fresh_bits;
                end
            end

            // Close any open sequence at the end of the text
            if (last_in)
            begin
                seq_len_next = SEQ_NONE;
                taken_next   = 2'd0;
                partial_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg    <= '0;
            seq_len_reg    <= SEQ_NONE;
            taken_reg      <= 2'd0;
            rep_reg        <= 2'd0;
            tail_valid_reg <= 1'b0;
        end
        else
        begin
            partial_reg    <= partial_next;
            seq_len_reg    <= seq_len_next;
            taken_reg      <= taken_next;
            rep_reg        <= rep_next;
            tail_valid_reg <= tail_valid_next;
        end
    end

    // Payload of the burst, no reset needed
    always_ff @(posedge clk)
    begin
        tail_cp_reg <= tail_cp_next;
        last_reg    <= last_next;
    end

endmodule
